// ===== hdl/vsu_pkg.sv =====
// shared types and constants of the vga scan-out pixel unpacker
`timescale 1ns / 1ps

package vsu_pkg;

    localparam int ADDR_W  = 16;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 9;
    localparam int PLANES  = 4;
    localparam int BYTE_W  = 8;
    localparam int PIXEL_W = 8;
    localparam int PITCH_W = 11;
    localparam int KIDX_W  = 3;

    typedef enum logic [1:0] {
        MODE_CGA       = 2'd0,
        MODE_PLANAR_HI = 2'd1,
        MODE_PLANAR_LO = 2'd2,
        MODE_CHAINED   = 2'd3
    } vmode_t;

    typedef enum logic [1:0] {
        ASIZE_BYTE  = 2'd0,
        ASIZE_WORD  = 2'd1,
        ASIZE_DWORD = 2'd2
    } asize_t;

    typedef enum logic [1:0] {
        REG_VIDEO_MODE    = 2'd0,
        REG_DISPLAY_START = 2'd1,
        REG_LINE_OFFSET   = 2'd2,
        REG_ADDRESS_SIZE  = 2'd3
    } reg_index_t;

    localparam logic [COL_W-1:0]   WIDTH_HI      = 10'd640;
    localparam logic [COL_W-1:0]   WIDTH_LO      = 10'd320;
    localparam logic [ROW_W-1:0]   HEIGHT_HI     = 9'd480;
    localparam logic [ROW_W-1:0]   HEIGHT_LO     = 9'd200;
    localparam logic [ADDR_W-1:0]  CGA_ODD_BANK  = 16'h2000;
    localparam logic [PITCH_W-1:0] PITCH_80      = 11'd80;
    localparam logic [PITCH_W-1:0] PITCH_40      = 11'd40;

    typedef struct packed {
        vmode_t             mode;
        logic [ADDR_W-1:0]  display_start;
        logic [7:0]         line_offset;
        logic [1:0]         address_size;
    } cfg_t;

    // one classified fetch waiting for the serialiser
    typedef struct packed {
        vmode_t                          mode;
        logic [PLANES-1:0][BYTE_W-1:0]   planes;
        logic [COL_W-1:0]                col;
        logic [ROW_W-1:0]                row;
        logic                            last_of_frame;
        logic [ADDR_W-1:0]               next_address;
    } q_entry_t;

endpackage

// ===== hdl/vsu_front.sv =====
// front end: accepts fetches, tracks the scan position and works out the next fetch address
`timescale 1ns / 1ps

module vsu_front (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  vsu_pkg::cfg_t                                 cfg,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [vsu_pkg::PLANES-1:0][vsu_pkg::BYTE_W-1:0] planes,
    output logic                                          q_push,
    output vsu_pkg::q_entry_t                             q_entry,
    input  logic                                          q_ready
);
    import vsu_pkg::*;

    logic [COL_W-1:0]   column_count_reg;
    logic [ROW_W-1:0]   row_count_reg;

    logic [COL_W-1:0]   width;
    logic [ROW_W-1:0]   height;
    logic               ppf8;
    logic [COL_W-1:0]   col_a;
    logic [ROW_W-1:0]   row_a;
    logic [COL_W:0]     ncol_wide;
    logic [COL_W-1:0]   ncol_a;
    logic [ROW_W-1:0]   nrow_a;
    logic               lof_a;
    logic               in_accept;

    logic                          sb_valid_reg;
    vmode_t                        sb_mode_reg;
    logic [PLANES-1:0][BYTE_W-1:0] sb_planes_reg;
    logic [COL_W-1:0]              sb_col_reg;
    logic [ROW_W-1:0]              sb_row_reg;
    logic [COL_W-1:0]              sb_ncol_reg;
    logic [ROW_W-1:0]              sb_nrow_reg;
    logic                          sb_lof_reg;

    logic [ROW_W-1:0]              mul_row;
    logic [PITCH_W-1:0]            pitch;
    logic [ROW_W+PITCH_W-1:0]      product;
    logic [ADDR_W-1:0]             col_term;
    logic [ADDR_W-1:0]             base;
    logic [ADDR_W-1:0]             bank;
    logic [ADDR_W-1:0]             wide_ncol;

    assign width  = (cfg.mode == MODE_PLANAR_HI) ? WIDTH_HI : WIDTH_LO;
    assign height = (cfg.mode == MODE_PLANAR_HI) ? HEIGHT_HI : HEIGHT_LO;
    assign ppf8   = (cfg.mode == MODE_PLANAR_HI) || (cfg.mode == MODE_PLANAR_LO);

    assign q_push    = sb_valid_reg && q_ready;
    assign in_ready  = !sb_valid_reg || q_ready;
    assign in_accept = in_valid && in_ready;

    // position of this fetch, pulled back into the frame after a mode change
    always_comb
    begin
        col_a = column_count_reg;
        row_a = row_count_reg;
        if (row_a >= height)
        begin
            row_a = '0;
            col_a = '0;
        end
        if (col_a >= width)
        begin
            col_a = '0;
            row_a = row_a + 9'd1;
            if (row_a >= height)
            begin
                row_a = '0;
            end
        end
        col_a = ppf8 ? {col_a[COL_W-1:3], 3'b000} : {col_a[COL_W-1:2], 2'b00};

        ncol_wide = {1'b0, col_a} + (ppf8 ? 11'd8 : 11'd4);
        ncol_a    = ncol_wide[COL_W-1:0];
        nrow_a    = row_a;
        lof_a     = 1'b0;
        if (ncol_wide >= {1'b0, width})
        begin
            ncol_a = '0;
            nrow_a = row_a + 9'd1;
            if (nrow_a >= height)
            begin
                nrow_a = '0;
                lof_a  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            sb_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                column_count_reg <= ncol_a;
                row_count_reg    <= nrow_a;
                sb_valid_reg     <= 1'b1;
            end
            else if (q_push)
            begin
                sb_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sb_mode_reg   <= cfg.mode;
            sb_planes_reg <= planes;
            sb_col_reg    <= col_a;
            sb_row_reg    <= row_a;
            sb_ncol_reg   <= ncol_a;
            sb_nrow_reg   <= nrow_a;
            sb_lof_reg    <= lof_a;
        end
    end

    // next fetch address: base + bank + line * pitch + column term
    assign wide_ncol = {{(ADDR_W-COL_W){1'b0}}, sb_ncol_reg};

    always_comb
    begin
        mul_row  = sb_nrow_reg;
        pitch    = PITCH_80;
        col_term = wide_ncol >> 3;
        case (sb_mode_reg)
            MODE_CGA:
            begin
                mul_row  = sb_nrow_reg >> 1;
                pitch    = PITCH_80;
                col_term = wide_ncol >> 2;
            end
            MODE_PLANAR_HI:
            begin
                pitch    = PITCH_80;
                col_term = wide_ncol >> 3;
            end
            MODE_PLANAR_LO:
            begin
                pitch    = PITCH_40;
                col_term = wide_ncol >> 3;
            end
            MODE_CHAINED:
            begin
                case (cfg.address_size)
                    ASIZE_BYTE:
                    begin
                        pitch    = {2'b00, cfg.line_offset, 1'b0};
                        col_term = wide_ncol >> 2;
                    end
                    ASIZE_DWORD:
                    begin
                        pitch    = {cfg.line_offset, 3'b000};
                        col_term = {wide_ncol[ADDR_W-1:2], 2'b00};
                    end
                    // word addressing, also for the unused size code
                    default:
                    begin
                        pitch    = {1'b0, cfg.line_offset, 2'b00};
                        col_term = {1'b0, wide_ncol[ADDR_W-1:2], 1'b0};
                    end
                endcase
            end
            default:
            begin
                pitch = PITCH_80;
            end
        endcase
    end

    assign product = {{PITCH_W{1'b0}}, mul_row} * {{ROW_W{1'b0}}, pitch};
    assign base    = (sb_mode_reg == MODE_PLANAR_HI) ? '0 : cfg.display_start;
    assign bank    = ((sb_mode_reg == MODE_CGA) && sb_nrow_reg[0]) ? CGA_ODD_BANK : '0;

    always_comb
    begin
        q_entry.mode          = sb_mode_reg;
        q_entry.planes        = sb_planes_reg;
        q_entry.col           = sb_col_reg;
        q_entry.row           = sb_row_reg;
        q_entry.last_of_frame = sb_lof_reg;
        q_entry.next_address  = base + bank + product[ADDR_W-1:0] + col_term;
    end

endmodule

// ===== hdl/vsu_queue.sv =====
// two-entry queue between the front end and the pixel serialiser
`timescale 1ns / 1ps

module vsu_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  vsu_pkg::q_entry_t  push_entry,
    output logic               push_ready,
    input  logic               pop,
    output vsu_pkg::q_entry_t  head,
    output logic               head_valid
);
    import vsu_pkg::*;

    q_entry_t    entries_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = entries_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== hdl/vsu_back.sv =====
// back end: turns each queued fetch into output register pixels, one per cycle unless stalled
`timescale 1ns / 1ps

module vsu_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  vsu_pkg::q_entry_t              head,
    input  logic                           head_valid,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [vsu_pkg::PIXEL_W-1:0]    pixel_value,
    output logic [vsu_pkg::COL_W-1:0]      pixel_column,
    output logic [vsu_pkg::ROW_W-1:0]      pixel_row,
    output logic                           fetch_done,
    output logic                           frame_done,
    output logic [vsu_pkg::ADDR_W-1:0]     next_fetch_address
);
    import vsu_pkg::*;

    logic [KIDX_W-1:0]   k_reg;
    logic                out_valid_reg;
    logic [PIXEL_W-1:0]  pixel_value_reg;
    logic [COL_W-1:0]    pixel_column_reg;
    logic [ROW_W-1:0]    pixel_row_reg;
    logic                fetch_done_reg;
    logic                frame_done_reg;
    logic [ADDR_W-1:0]   next_fetch_address_reg;

    logic                load;
    logic                ppf8;
    logic                last;
    logic [PIXEL_W-1:0]  pix;
    logic [2:0]          bit_idx;
    logic [2:0]          cga_idx;

    assign ppf8    = (head.mode == MODE_PLANAR_HI) || (head.mode == MODE_PLANAR_LO);
    assign last    = ppf8 ? (k_reg == 3'd7) : (k_reg == 3'd3);
    assign load    = head_valid && (!out_valid_reg || out_ready);
    assign pop     = load && last;
    assign bit_idx = 3'd7 - k_reg;
    assign cga_idx = 3'd7 - {k_reg[1:0], 1'b0};

    always_comb
    begin
        case (head.mode)
            MODE_CGA:
            begin
                pix = {6'd0, head.planes[0][cga_idx -: 2]};
            end
            MODE_CHAINED:
            begin
                pix = head.planes[k_reg[1:0]];
            end
            default:
            begin
                // planar: plane n gives bit n
                pix = {4'd0, head.planes[3][bit_idx], head.planes[2][bit_idx],
                       head.planes[1][bit_idx], head.planes[0][bit_idx]};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                k_reg         <= last ? '0 : k_reg + 3'd1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pixel_value_reg        <= pix;
            pixel_column_reg       <= head.col + {{(COL_W-KIDX_W){1'b0}}, k_reg};
            pixel_row_reg          <= head.row;
            fetch_done_reg         <= last;
            frame_done_reg         <= last && head.last_of_frame;
            next_fetch_address_reg <= last ? head.next_address : '0;
        end
    end

    assign out_valid          = out_valid_reg;
    assign pixel_value        = pixel_value_reg;
    assign pixel_column       = pixel_column_reg;
    assign pixel_row          = pixel_row_reg;
    assign fetch_done         = fetch_done_reg;
    assign frame_done         = frame_done_reg;
    assign next_fetch_address = next_fetch_address_reg;

endmodule

// ===== hdl/vga_scanout_pixel_unpacker.sv =====
// top level of the vga scan-out pixel unpacker
// Usage: each input transaction carries the four plane bytes read at the fetch address
// announced last (next_fetch_address on the previous fetch_done pixel). Each output
// transaction carries one pixel with its column and row; the last pixel of a fetch sets
// fetch_done and carries the address of the next fetch, and the last of the frame also
// sets frame_done. Modes 0 and 3 give four pixels per fetch, modes 1 and 2 give eight.
// Configuration must be written through cfg_write / cfg_index / cfg_data while idle;
// the block does not enforce this. A fetch passes the front-end register, a queue entry
// and the serialiser output register. Throughput: one pixel per cycle while out_ready
// is high, limited by the serialiser output register. The front end registers the scan
// position and fetch, the next fetch address is formed from that register, and a two-entry
// queue feeds the serialiser, so new fetches are taken while earlier pixels still drain.
// Reset: position returns to column 0 of line 0, registers take their reset values
// (mode 0, start 0, line offset 0, word addressing); the first fetch starts a frame.
// Stall: with out_ready low the output register holds its pixel, the queue fills up and
// in_ready then drops until pixels are taken again.
`timescale 1ns / 1ps

module vga_scanout_pixel_unpacker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [1:0]                     cfg_index,
    input  logic [15:0]                    cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [vsu_pkg::BYTE_W-1:0]     plane0_byte,
    input  logic [vsu_pkg::BYTE_W-1:0]     plane1_byte,
    input  logic [vsu_pkg::BYTE_W-1:0]     plane2_byte,
    input  logic [vsu_pkg::BYTE_W-1:0]     plane3_byte,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [vsu_pkg::PIXEL_W-1:0]    pixel_value,
    output logic [vsu_pkg::COL_W-1:0]      pixel_column,
    output logic [vsu_pkg::ROW_W-1:0]      pixel_row,
    output logic                           fetch_done,
    output logic                           frame_done,
    output logic [vsu_pkg::ADDR_W-1:0]     next_fetch_address
);
    import vsu_pkg::*;

    cfg_t                           cfg_reg;
    logic [PLANES-1:0][BYTE_W-1:0]  planes;
    logic                           q_push;
    logic                           q_ready;
    q_entry_t                       q_entry;
    q_entry_t                       q_head;
    logic                           q_head_valid;
    logic                           q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode          <= MODE_CGA;
            cfg_reg.display_start <= '0;
            cfg_reg.line_offset   <= '0;
            cfg_reg.address_size  <= ASIZE_WORD;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_VIDEO_MODE:    cfg_reg.mode          <= vmode_t'(cfg_data[1:0]);
                REG_DISPLAY_START: cfg_reg.display_start <= cfg_data;
                REG_LINE_OFFSET:   cfg_reg.line_offset   <= cfg_data[7:0];
                REG_ADDRESS_SIZE:  cfg_reg.address_size  <= cfg_data[1:0];
                default:           cfg_reg.mode          <= cfg_reg.mode;
            endcase
        end
    end

    assign planes = {plane3_byte, plane2_byte, plane1_byte, plane0_byte};

    vsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .planes   (planes),
        .q_push   (q_push),
        .q_entry  (q_entry),
        .q_ready  (q_ready)
    );

    vsu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_head_valid)
    );

    vsu_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .head               (q_head),
        .head_valid         (q_head_valid),
        .pop                (q_pop),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .pixel_value        (pixel_value),
        .pixel_column       (pixel_column),
        .pixel_row          (pixel_row),
        .fetch_done         (fetch_done),
        .frame_done         (frame_done),
        .next_fetch_address (next_fetch_address)
    );

`ifndef NO_ASSERTIONS
    a_frame_ends_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |-> fetch_done)
        else $error("frame_done without fetch_done");

    a_addr_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !fetch_done) |-> (next_fetch_address == '0))
        else $error("next fetch address shown on a pixel inside a fetch");

    a_pixel_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((pixel_column < WIDTH_HI) && (pixel_row < HEIGHT_HI)))
        else $error("pixel position outside the frame");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |=> q_head_valid)
        else $error("queue lost a pushed fetch");
`endif

endmodule

// ===== sim/tb.sv =====
// testbench for the vga scan-out pixel unpacker: fetches driven through the handshake, pixels checked against a predictor
`timescale 1ns / 1ps

import vsu_pkg::*;

typedef struct {
    logic [PIXEL_W-1:0] value;
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;
    logic               fetch_last;
    logic               frame_last;
    logic [ADDR_W-1:0]  next_addr;
} scan_pixel_t;

class scanout_scoreboard;
    vmode_t      mode;
    logic [15:0] start_addr;
    logic [7:0]  line_off;
    logic [1:0]  addr_size;
    int unsigned col_pos;
    int unsigned row_pos;
    scan_pixel_t expected_pixels[$];
    int          errors;

    function new();
        mode = MODE_CGA;
        start_addr = '0;
        line_off = '0;
        addr_size = ASIZE_WORD;
        col_pos = 0;
        row_pos = 0;
        errors = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [15:0] data);
        case (idx)
            REG_VIDEO_MODE:    mode = vmode_t'(data[1:0]);
            REG_DISPLAY_START: start_addr = data;
            REG_LINE_OFFSET:   line_off = data[7:0];
            default:           addr_size = data[1:0];
        endcase
    endfunction

    function int unsigned pending();
        return expected_pixels.size();
    endfunction

    // per-plane byte offset of the fetch starting at column c of line r
    function int unsigned fetch_offset(int unsigned r, int unsigned c);
        int unsigned a;
        int unsigned lo;
        lo = line_off;
        case (mode)
            MODE_CGA:
                a = start_addr + ((r & 1) ? CGA_ODD_BANK : 0) + (r >> 1) * PITCH_80 + (c >> 2);
            MODE_PLANAR_HI:
                a = r * PITCH_80 + (c >> 3);
            MODE_PLANAR_LO:
                a = start_addr + r * PITCH_40 + (c >> 3);
            default:
            begin
                case (addr_size)
                    ASIZE_BYTE:  a = start_addr + r * (lo << 1) + (c >> 2);
                    ASIZE_DWORD: a = start_addr + r * (lo << 3) + (c & ~32'd3);
                    // word, and the unused size code behaves as word
                    default:     a = start_addr + r * (lo << 2) + ((c >> 1) & ~32'd1);
                endcase
            end
        endcase
        return a & 32'hFFFF;
    endfunction

    function void note_fetch(logic [7:0] p0, logic [7:0] p1, logic [7:0] p2, logic [7:0] p3);
        logic [7:0]  b [4];
        int unsigned w;
        int unsigned h;
        int unsigned ppf;
        int unsigned c;
        int unsigned r;
        int unsigned nc;
        int unsigned nr;
        int unsigned nxt;
        logic        lof;
        scan_pixel_t e;
        b[0] = p0;
        b[1] = p1;
        b[2] = p2;
        b[3] = p3;
        w = (mode == MODE_PLANAR_HI) ? WIDTH_HI : WIDTH_LO;
        h = (mode == MODE_PLANAR_HI) ? HEIGHT_HI : HEIGHT_LO;
        ppf = (mode == MODE_PLANAR_HI || mode == MODE_PLANAR_LO) ? 8 : 4;
        c = col_pos;
        r = row_pos;
        // position left outside the frame by a mode change
        if (r >= h)
        begin
            r = 0;
            c = 0;
        end
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        c = c & ~(ppf - 1);
        nc = c + ppf;
        nr = r;
        lof = 1'b0;
        if (nc >= w)
        begin
            nc = 0;
            nr = r + 1;
            if (nr >= h)
            begin
                nr = 0;
                lof = 1'b1;
            end
        end
        nxt = fetch_offset(nr, nc);
        for (int k = 0; k < ppf; k++)
        begin
            case (mode)
                MODE_CGA:     e.value = (b[0] >> (6 - 2 * k)) & 8'd3;
                MODE_CHAINED: e.value = b[k];
                default:      e.value = {4'd0, b[3][7-k], b[2][7-k], b[1][7-k], b[0][7-k]};
            endcase
            e.column = COL_W'(c + k);
            e.row = ROW_W'(r);
            e.fetch_last = (k == ppf - 1);
            e.frame_last = e.fetch_last && lof;
            e.next_addr = e.fetch_last ? nxt[15:0] : '0;
            expected_pixels.push_back(e);
        end
        col_pos = nc;
        row_pos = nr;
    endfunction

    task report_mismatch(string what);
        errors++;
        if (errors <= 30)
            $display("mismatch: %s", what);
    endtask

    task check_pixel(logic [7:0] v, logic [9:0] col, logic [8:0] row, logic fd, logic frd,
                     logic [15:0] na);
        scan_pixel_t e;
        if (expected_pixels.size() == 0)
        begin
            report_mismatch($sformatf("pixel at (%0d,%0d) with none expected", col, row));
            return;
        end
        e = expected_pixels.pop_front();
        if (v !== e.value)
            report_mismatch($sformatf("pixel_value %0h, wanted %0h at (%0d,%0d)",
                                      v, e.value, e.column, e.row));
        if (col !== e.column)
            report_mismatch($sformatf("pixel_column %0d, wanted %0d", col, e.column));
        if (row !== e.row)
            report_mismatch($sformatf("pixel_row %0d, wanted %0d", row, e.row));
        if (fd !== e.fetch_last)
            report_mismatch($sformatf("fetch_done %b, wanted %b at (%0d,%0d)",
                                      fd, e.fetch_last, e.column, e.row));
        if (frd !== e.frame_last)
            report_mismatch($sformatf("frame_done %b, wanted %b at (%0d,%0d)",
                                      frd, e.frame_last, e.column, e.row));
        if (na !== e.next_addr)
            report_mismatch($sformatf("next_fetch_address %0h, wanted %0h at (%0d,%0d)",
                                      na, e.next_addr, e.column, e.row));
    endtask
endclass

module tb;
    localparam int         CYCLE_LIMIT     = 2000000;
    localparam int         HOLD_CYCLES     = 300;
    localparam logic [1:0] ASIZE_RESERVED  = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  plane0_byte = '0;
    logic [7:0]  plane1_byte = '0;
    logic [7:0]  plane2_byte = '0;
    logic [7:0]  plane3_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  pixel_value;
    logic [9:0]  pixel_column;
    logic [8:0]  pixel_row;
    logic        fetch_done;
    logic        frame_done;
    logic [15:0] next_fetch_address;

    bit no_stall = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;

    scanout_scoreboard sb = new();

    vga_scanout_pixel_unpacker uut (.*);

    always #10 clk = ~clk;

    // receiver side: random back-pressure, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= no_stall || ($urandom_range(0, 99) >= 21);
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            sb.check_pixel(pixel_value, pixel_column, pixel_row, fetch_done, frame_done,
                           next_fetch_address);

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_value(logic [15:0] top);
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return top;
            default: return 16'($urandom_range(0, top));
        endcase
    endfunction

    task automatic write_reg(input reg_index_t idx, input logic [15:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic send_fetch(input logic [7:0] b0, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] b3);
        @(negedge clk);
        in_valid <= 1'b1;
        plane0_byte <= b0;
        plane1_byte <= b1;
        plane2_byte <= b2;
        plane3_byte <= b3;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_fetch(b0, b1, b2, b3);
    endtask

    task automatic send_random_fetch();
        send_fetch(rand_byte(), rand_byte(), rand_byte(), rand_byte());
    endtask

    task automatic pause_input(input int n);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic wait_drained();
        pause_input(1);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_phase(input int n_items, input bit with_hold, input bit with_pause);
        wait_drained();
        write_reg(REG_VIDEO_MODE, 16'($urandom_range(0, 3)));
        write_reg(REG_DISPLAY_START, pick_value(16'hFFFF));
        write_reg(REG_LINE_OFFSET, pick_value(16'h00FF));
        write_reg(REG_ADDRESS_SIZE, 16'($urandom_range(0, 3)));
        for (int i = 0; i < n_items; i++)
        begin
            if ($urandom_range(0, 99) < 21)
                pause_input($urandom_range(1, 12));
            if (with_pause && i == n_items / 2)
                wait_drained();
            send_random_fetch();
            if (with_hold && i == 1)
                hold_req = 1'b1;
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: cga, first fetch opens the frame
        send_fetch(8'h00, 8'h00, 8'h00, 8'h00);
        send_fetch(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_fetch(8'h1B, 8'h00, 8'h00, 8'h00);
        send_fetch(8'hE4, 8'hA5, 8'h5A, 8'hC3);

        wait_drained();
        write_reg(REG_VIDEO_MODE, 16'(MODE_PLANAR_HI));
        write_reg(REG_DISPLAY_START, 16'hFFFF);
        write_reg(REG_LINE_OFFSET, 16'h00FF);
        write_reg(REG_ADDRESS_SIZE, 16'(ASIZE_DWORD));
        send_fetch(8'h01, 8'h02, 8'h04, 8'h08);
        send_fetch(8'h80, 8'h40, 8'h20, 8'h10);
        send_fetch(8'hFF, 8'h00, 8'hFF, 8'h00);
        send_fetch(8'h00, 8'hFF, 8'h00, 8'hFF);

        wait_drained();
        write_reg(REG_VIDEO_MODE, 16'(MODE_PLANAR_LO));
        send_fetch(8'hAA, 8'h55, 8'hCC, 8'h33);
        send_fetch(8'h0F, 8'hF0, 8'h3C, 8'hC3);

        // four-pixel step leaves the column off an eight-pixel boundary
        wait_drained();
        write_reg(REG_VIDEO_MODE, 16'(MODE_CGA));
        send_fetch(8'hC6, 8'h11, 8'h22, 8'h44);
        wait_drained();
        write_reg(REG_VIDEO_MODE, 16'(MODE_PLANAR_LO));
        send_fetch(8'h96, 8'h69, 8'hF0, 8'h0F);

        wait_drained();
        write_reg(REG_VIDEO_MODE, 16'(MODE_CHAINED));
        write_reg(REG_ADDRESS_SIZE, 16'(ASIZE_BYTE));
        send_fetch(8'h00, 8'h7F, 8'h80, 8'hFF);
        send_fetch(8'h12, 8'h34, 8'h56, 8'h78);
        wait_drained();
        write_reg(REG_ADDRESS_SIZE, 16'(ASIZE_WORD));
        write_reg(REG_LINE_OFFSET, 16'h0000);
        send_fetch(8'hFE, 8'hDC, 8'hBA, 8'h98);
        wait_drained();
        write_reg(REG_ADDRESS_SIZE, 16'(ASIZE_DWORD));
        send_fetch(8'h01, 8'h10, 8'hEF, 8'hFE);
        wait_drained();
        write_reg(REG_ADDRESS_SIZE, 16'(ASIZE_RESERVED));
        send_fetch(8'h5A, 8'hA5, 8'h3C, 8'hC3);
        send_fetch(8'hFF, 8'h00, 8'h00, 8'hFF);

        // full-rate stretch: hi-res run to a column past the 320-pixel line width,
        // then back to cga
        wait_drained();
        no_stall = 1'b1;
        write_reg(REG_VIDEO_MODE, 16'(MODE_PLANAR_HI));
        while (sb.col_pos <= WIDTH_LO)
            send_random_fetch();
        wait_drained();
        write_reg(REG_VIDEO_MODE, 16'(MODE_CGA));
        send_random_fetch();
        wait_drained();
        no_stall = 1'b0;

        random_phase(12, 1'b0, 1'b0);
        random_phase(12, 1'b1, 1'b0);
        random_phase(12, 1'b0, 1'b0);
        random_phase(12, 1'b0, 1'b1);
        random_phase(12, 1'b0, 1'b0);

        wait_drained();
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== sim.f =====
hdl/vsu_pkg.sv
hdl/vsu_front.sv
hdl/vsu_queue.sv
hdl/vsu_back.sv
hdl/vga_scanout_pixel_unpacker.sv
sim/tb.sv
